>>> rtl/whole_word_caseless_matcher_unit_assert.svh
// Assertion helpers for the whole word matcher.
// Each macro checks a property on clk, switched off while arst_n is low.
`ifndef WHOLE_WORD_CASELESS_MATCHER_UNIT_ASSERT_SVH
`define WHOLE_WORD_CASELESS_MATCHER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WWCM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WWCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define WWCM_ASSERT_NOW(label, ante, cons, msg)
`define WWCM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/wwcm_pkg.sv
`timescale 1ns / 1ps

package wwcm_pkg;

	localparam int WordMax   = 8;
	localparam int HistDepth = WordMax + 1;
	localparam int CharsW    = 8 * WordMax;
	localparam int LenW      = 4;
	localparam int SelW      = (WordMax > 1) ? $clog2(WordMax) : 1;

	localparam logic [7:0] CharLowA = 8'h61;  // 'a'
	localparam logic [7:0] CharLowZ = 8'h7a;  // 'z'
	localparam logic [7:0] CharUpA  = 8'h41;  // 'A'
	localparam logic [7:0] CharUpZ  = 8'h5a;  // 'Z'
	localparam logic [7:0] CharCaseBit = 8'h20;  // 'a' - 'A', also ' '

	localparam logic [CharsW-1:0] FirstCharsRst  = 64'd435728772973;    // "mouse"
	localparam logic [LenW-1:0]   FirstLenRst    = 4'd5;
	localparam logic [CharsW-1:0] SecondCharsRst = 64'd127978958905716; // "tablet"
	localparam logic [LenW-1:0]   SecondLenRst   = 4'd6;

	typedef enum logic [1:0] {
		REG_FIRST_CHARS  = 2'd0,
		REG_FIRST_LEN    = 2'd1,
		REG_SECOND_CHARS = 2'd2,
		REG_SECOND_LEN   = 2'd3
	} cfg_reg_t;

	// newest byte at index 0, all bytes case folded
	typedef logic [HistDepth-1:0][7:0] win_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= CharUpA && c <= CharUpZ) begin
			return c | CharCaseBit;
		end
		return c;
	endfunction

	// letter test on an already folded byte
	function automatic logic is_lower(input logic [7:0] c);
		return (c >= CharLowA) && (c <= CharLowZ);
	endfunction

	function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
		if (len == '0) begin
			return LenW'(1);
		end
		if (len > LenW'(WordMax)) begin
			return LenW'(WordMax);
		end
		return len;
	endfunction

endpackage

>>> rtl/wwcm_word_check.sv
`timescale 1ns / 1ps

// Word compare against one window plus the leading boundary test.
module wwcm_word_check
	import wwcm_pkg::*;
(
	input  win_t              win,
	input  logic [LenW-1:0]   avail,
	input  logic [CharsW-1:0] chars,
	input  logic [LenW-1:0]   len,
	output logic              hit
);

	logic chars_ok;

	always_comb begin
		logic [SelW-1:0] sel;
		chars_ok = 1'b1;
		for (int j = 0; j < WordMax; j++) begin
			// window byte j meets word character len-1-j
			sel = SelW'(len - LenW'(1) - LenW'(j));
			if ((LenW'(j) < len) && (win[j] != chars[8*sel +: 8])) begin
				chars_ok = 1'b0;
			end
		end
	end

	always_comb begin
		if (avail < len) begin
			hit = 1'b0;
		end else if (avail == len) begin
			hit = chars_ok;  // word starts the name
		end else begin
			hit = chars_ok && !is_lower(win[len]);
		end
	end

endmodule

>>> rtl/whole_word_caseless_matcher_unit.sv
`timescale 1ns / 1ps

// Whole word, case-insensitive search of a byte stream for two configured
// words. One item (one name byte) is accepted per cycle while the output is
// not stalled, and gives one result item carrying the sticky found flags so
// far in the name, through an input register and a result register with the
// window compare between them. The rate is set by that compare of both words
// against the nine-byte history. in_ready follows out_ready in the same
// cycle. Write configuration only while no item is in flight.
module whole_word_caseless_matcher_unit
	import wwcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [CharsW-1:0] cfg_wdata,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        name_byte,
	input  logic              name_end,

	output logic              out_valid,
	input  logic              out_ready,
	output logic              first_found,
	output logic              second_found,
	output logic              end_of_name
);

	logic [CharsW-1:0] first_chars_q, second_chars_q;
	logic [LenW-1:0]   first_len_q, second_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_chars_q  <= FirstCharsRst;
			first_len_q    <= FirstLenRst;
			second_chars_q <= SecondCharsRst;
			second_len_q   <= SecondLenRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_FIRST_CHARS:  first_chars_q  <= cfg_wdata;
				REG_FIRST_LEN:    first_len_q    <= cfg_wdata[LenW-1:0];
				REG_SECOND_CHARS: second_chars_q <= cfg_wdata;
				REG_SECOND_LEN:   second_len_q   <= cfg_wdata[LenW-1:0];
			endcase
		end
	end

	logic [LenW-1:0] first_len, second_len;
	assign first_len  = eff_len(first_len_q);
	assign second_len = eff_len(second_len_q);

	// pipeline control
	logic valid_s1, valid_s2, advance;
	logic [7:0] byte_s1;
	logic end_s1;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= name_byte;
			end_s1  <= name_end;
		end
	end

	// name state
	win_t            hist_q;
	logic [LenW-1:0] seen_q;
	logic            first_hit_q, second_hit_q;

	logic [7:0]      byte_f;
	logic            byte_letter;
	win_t            cur_win;
	logic [LenW-1:0] cur_avail;
	logic            f_prev, s_prev, f_cur, s_cur;
	logic            first_next, second_next;

	assign byte_f      = fold(byte_s1);
	assign byte_letter = is_lower(byte_f);
	assign cur_win     = {hist_q[HistDepth-2:0], byte_f};
	assign cur_avail   = seen_q + LenW'(1);

	wwcm_word_check u_first_prev (
		.win(hist_q), .avail(seen_q), .chars(first_chars_q), .len(first_len), .hit(f_prev)
	);
	wwcm_word_check u_second_prev (
		.win(hist_q), .avail(seen_q), .chars(second_chars_q), .len(second_len), .hit(s_prev)
	);
	wwcm_word_check u_first_cur (
		.win(cur_win), .avail(cur_avail), .chars(first_chars_q), .len(first_len), .hit(f_cur)
	);
	wwcm_word_check u_second_cur (
		.win(cur_win), .avail(cur_avail), .chars(second_chars_q), .len(second_len), .hit(s_cur)
	);

	// previous window needs a non-letter after it; current one needs the name end
	assign first_next  = first_hit_q  || (!byte_letter && f_prev) || (end_s1 && f_cur);
	assign second_next = second_hit_q || (!byte_letter && s_prev) || (end_s1 && s_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q       <= '0;
			seen_q       <= '0;
			first_hit_q  <= 1'b0;
			second_hit_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (end_s1) begin
				hist_q       <= '0;
				seen_q       <= '0;
				first_hit_q  <= 1'b0;
				second_hit_q <= 1'b0;
			end else begin
				hist_q       <= cur_win;
				first_hit_q  <= first_next;
				second_hit_q <= second_next;
				if (seen_q < LenW'(HistDepth)) begin
					seen_q <= seen_q + LenW'(1);
				end
			end
		end
	end

	// result register
	logic first_s2, second_s2, end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			first_s2  <= first_next;
			second_s2 <= second_next;
			end_s2    <= end_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign first_found  = first_s2;
	assign second_found = second_s2;
	assign end_of_name  = end_s2;

`include "whole_word_caseless_matcher_unit_assert.svh"

	`WWCM_ASSERT_NOW(a_seen_sat, 1'b1, seen_q <= LenW'(HistDepth), "byte count past saturation")
	`WWCM_ASSERT_NEXT(a_name_clear, valid_s1 && advance && end_s1, seen_q == '0 && !first_hit_q && !second_hit_q, "name state not cleared after name end")
	`WWCM_ASSERT_NEXT(a_hit_sticky, valid_s1 && advance && !end_s1 && first_next, first_hit_q, "first found flag lost inside a name")
	`WWCM_ASSERT_NOW(a_ready_empty, !valid_s2, in_ready, "input stalled with empty result register")

endmodule
